// File: rtl/biu_pkg.sv
package biu_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int SCALE_W       = 3;
  localparam int IMG_W_W       = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int PIX_W         = 8;
  localparam int COORD_W       = 12;
  localparam int NUM_W         = 13;  // signed interpolation numerator, 0..4080
  localparam int DX_W          = 12;  // signed per-column / per-row increments
  localparam int DDX_W         = 10;
  localparam int RECIP_W       = 17;
  localparam int RECIP_SH      = 17;
  localparam int PROD_W        = 30;
  localparam int STEP_W        = 3;   // offset inside one emitted block, up to 2S-1

  localparam logic [SCALE_W-1:0] SCALE_RESET = 3'd2;
  localparam logic [SCALE_W-1:0] SCALE_MAX   = 3'd4;
  localparam logic [IMG_W_W-1:0] WIDTH_RESET = 11'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE       = 2'd0,
    REG_IMAGE_WIDTH = 2'd1
  } biu_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } biu_state_e;

  // sequencer commands to the interpolation unit
  typedef struct packed {
    logic load;     // take new neighborhood, start at offset (0,0)
    logic adv;      // step to the next output of the block
    logic row_end;  // current output is the last of its row
    logic x_in;     // column offset below S: column weight still moves
    logic y_in;     // row offset below S: row weight still moves
  } biu_ctrl_t;

  // S squared, the divisor of the numerator
  function automatic logic [4:0] scale_sq(input logic [SCALE_W-1:0] s);
    logic [4:0] r;
    case (s)
      3'd1:    r = 5'd1;
      3'd2:    r = 5'd4;
      3'd3:    r = 5'd9;
      default: r = 5'd16;
    endcase
    return r;
  endfunction

  // ceil(2^17 / (2*S^2)); exact floor for every numerator that occurs
  function automatic logic [RECIP_W-1:0] recip_mult(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] r;
    case (s)
      3'd1:    r = 17'd65536;
      3'd2:    r = 17'd16384;
      3'd3:    r = 17'd7282;
      default: r = 17'd4096;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/biu_interp_unit.sv
module biu_interp_unit (
  input  logic                      clk_i,
  input  biu_pkg::biu_ctrl_t        ctrl_i,
  input  logic [biu_pkg::SCALE_W-1:0] scale_i,
  input  logic [biu_pkg::PIX_W-1:0] p00_i,
  input  logic [biu_pkg::PIX_W-1:0] p01_i,
  input  logic [biu_pkg::PIX_W-1:0] p10_i,
  input  logic [biu_pkg::PIX_W-1:0] p11_i,
  output logic [biu_pkg::PIX_W-1:0] value_o
);
  import biu_pkg::*;

  logic signed [NUM_W-1:0]  num_q, num_d;
  logic signed [NUM_W-1:0]  rowbase_q, rowbase_d;
  logic signed [DX_W-1:0]   dx_q, dx_d;
  logic signed [DX_W-1:0]   e_q, e_d;
  logic signed [DDX_W-1:0]  ddx_q, ddx_d;

  logic signed [DX_W-1:0]   a_ext, b_ext, col0_ext, s_ext;
  logic [4:0]               s2;
  logic [NUM_W-1:0]         numer;
  logic [PROD_W-1:0]        prod;
  logic [NUM_W-1:0]         quot;

  always_comb begin
    s2       = scale_sq(scale_i);
    s_ext    = $signed({{(DX_W-SCALE_W){1'b0}}, scale_i});
    a_ext    = $signed({4'd0, p01_i}) - $signed({4'd0, p00_i});
    b_ext    = $signed({4'd0, p11_i}) - $signed({4'd0, p10_i});
    col0_ext = $signed({4'd0, p10_i}) - $signed({4'd0, p00_i});

    num_d     = num_q;
    rowbase_d = rowbase_q;
    dx_d      = dx_q;
    e_d       = e_q;
    ddx_d     = ddx_q;

    if (ctrl_i.load) begin
      rowbase_d = $signed(NUM_W'({5'd0, s2} * {5'd0, p00_i}));
      num_d     = rowbase_d;
      dx_d      = s_ext * a_ext;
      e_d       = s_ext * col0_ext;
      ddx_d     = DDX_W'(b_ext - a_ext);
    end else if (ctrl_i.adv) begin
      if (ctrl_i.row_end) begin
        // start the next row; rows past S repeat the last weight
        if (ctrl_i.y_in) begin
          rowbase_d = rowbase_q + NUM_W'(e_q);
          dx_d      = dx_q + DX_W'(ddx_q);
        end
        num_d = rowbase_d;
      end else if (ctrl_i.x_in) begin
        num_d = num_q + NUM_W'(dx_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q     <= num_d;
    rowbase_q <= rowbase_d;
    dx_q      <= dx_d;
    e_q       <= e_d;
    ddx_q     <= ddx_d;
  end

  // round half up of num / S^2 as floor((2*num + S^2) / (2*S^2))
  always_comb begin
    numer   = {num_q[NUM_W-2:0], 1'b0} + NUM_W'(s2);
    prod    = PROD_W'(numer) * PROD_W'(recip_mult(scale_i));
    quot    = prod[PROD_W-1:RECIP_SH];
    value_o = (quot > NUM_W'(255)) ? 8'hFF : quot[PIX_W-1:0];
  end

endmodule

// File: rtl/bilinear_image_upscaler_unit.sv
// Bilinear upscaler: accepts pixels of a square W x W image in raster order and returns the
// (W*S) x (W*S) image, each result tagged with its output row and column. Pixels of the first
// source row and column only fill the line buffer and give no result. Every later pixel gives
// an S x S block (2S wide on the last column, 2S tall on the last row), one result per cycle
// while the output side takes them, and last marks the final result of that pixel. An item
// goes through the buffer read and setup and then emits its results; the accumulator that
// steps the weights column by column gives one result a cycle while the output is not stalled.
// Input stall stays high through setup and emission, so no new pixel is taken until it ends.
// Writing scale or image_width restarts the image at its top-left pixel.
module bilinear_image_upscaler_unit #(
  parameter int MAX_WIDTH = biu_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [biu_pkg::PIX_W-1:0]     pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [biu_pkg::COORD_W-1:0]   out_row_o,
  output logic [biu_pkg::COORD_W-1:0]   out_col_o,
  output logic [biu_pkg::PIX_W-1:0]     value_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [biu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [biu_pkg::IMG_W_W-1:0]   cfg_data_i
);
  import biu_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  biu_state_e            state_q, state_d;
  logic [SCALE_W-1:0]    scale_q;
  logic [IMG_W_W-1:0]    width_q;
  logic [CW-1:0]         row_q, col_q;
  logic [PIX_W-1:0]      left_q, ul_q, pix_q, rd_q;
  logic [COORD_W-1:0]    blk_row_q, blk_col_q;
  logic [3:0]            rows_q, cols_q;
  logic                  has_blk_q;
  logic [STEP_W-1:0]     x_q, y_q;
  logic                  out_valid_q;
  logic [COORD_W-1:0]    out_row_q, out_col_q;
  logic [PIX_W-1:0]      value_q;
  logic                  last_q;
  logic [PIX_W-1:0]      line_mem [MAX_WIDTH];

  logic [SCALE_W-1:0]    s_eff;
  logic [12:0]           w_sel;
  logic [WW-1:0]         w_eff;
  logic [CW-1:0]         r_cur, c_cur;
  logic                  in_acc, cfg_acc, cfg_hit;
  logic                  emit_load, row_end, blk_last;
  logic                  last_row, last_col;
  biu_ctrl_t             ctrl;
  logic [PIX_W-1:0]      interp_val;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_acc && (cfg_index_i == REG_SCALE || cfg_index_i == REG_IMAGE_WIDTH);

  always_comb begin
    if (scale_q == '0) begin
      s_eff = 3'd1;
    end else if (scale_q > SCALE_MAX) begin
      s_eff = SCALE_MAX;
    end else begin
      s_eff = scale_q;
    end
    w_sel = {2'b00, width_q};
    if (w_sel < 13'd2) begin
      w_sel = 13'd2;
    end else if (w_sel > 13'(MAX_WIDTH)) begin
      w_sel = 13'(MAX_WIDTH);
    end
    w_eff = w_sel[WW-1:0];
    // out-of-range position starts a new image
    if ({1'b0, row_q} >= w_eff || {1'b0, col_q} >= w_eff) begin
      r_cur = '0;
      c_cur = '0;
    end else begin
      r_cur = row_q;
      c_cur = col_q;
    end
    last_row = ({1'b0, r_cur} == w_eff - WW'(1));
    last_col = ({1'b0, c_cur} == w_eff - WW'(1));
  end

  // line buffer: read-first, the old entry is the pixel above
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q           <= line_mem[c_cur];
      line_mem[c_cur] <= pixel_i;
    end
  end

  always_comb begin
    emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
    row_end   = ({1'b0, x_q} == cols_q - 4'd1);
    blk_last  = row_end && ({1'b0, y_q} == rows_q - 4'd1);
    ctrl.load    = (state_q == ST_LOAD);
    ctrl.adv     = emit_load;
    ctrl.row_end = row_end;
    ctrl.x_in    = (x_q < s_eff);
    ctrl.y_in    = (y_q < s_eff);
  end

  biu_interp_unit u_interp (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .scale_i (s_eff),
    .p00_i   (ul_q),
    .p01_i   (rd_q),
    .p10_i   (left_q),
    .p11_i   (pix_q),
    .value_o (interp_val)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = has_blk_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_load && blk_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration, position counters and neighborhood pixels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      width_q <= WIDTH_RESET;
      row_q   <= '0;
      col_q   <= '0;
      left_q  <= '0;
      ul_q    <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index_i)
          REG_SCALE:       scale_q <= cfg_data_i[SCALE_W-1:0];
          REG_IMAGE_WIDTH: width_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        row_q <= '0;
        col_q <= '0;
      end else if (in_acc) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : r_cur + CW'(1);
        end else begin
          row_q <= r_cur;
          col_q <= c_cur + CW'(1);
        end
      end
      if (state_q == ST_LOAD) begin
        ul_q   <= rd_q;
        left_q <= pix_q;
      end
    end
  end

  // per-item block geometry
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q     <= pixel_i;
      has_blk_q <= (r_cur != '0) && (c_cur != '0);
      blk_row_q <= COORD_W'(COORD_W'(r_cur - CW'(1)) * COORD_W'(s_eff));
      blk_col_q <= COORD_W'(COORD_W'(c_cur - CW'(1)) * COORD_W'(s_eff));
      rows_q    <= last_row ? {s_eff, 1'b0} : {1'b0, s_eff};
      cols_q    <= last_col ? {s_eff, 1'b0} : {1'b0, s_eff};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      x_q <= '0;
      y_q <= '0;
    end else if (emit_load) begin
      if (row_end) begin
        x_q <= '0;
        y_q <= y_q + STEP_W'(1);
      end else begin
        x_q <= x_q + STEP_W'(1);
      end
    end
  end

  // output register: holds a result while the next one is prepared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_row_q <= blk_row_q + COORD_W'(y_q);
      out_col_q <= blk_col_q + COORD_W'(x_q);
      value_q   <= interp_val;
      last_q    <= blk_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

  a_accept_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_LOAD))
    else $error("accepted item did not start the buffer read");

  a_offset_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> ({1'b0, x_q} < cols_q && {1'b0, y_q} < rows_q))
    else $error("block offset outside block");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && blk_last) |=> (state_q == ST_IDLE && out_valid_q && last_q))
    else $error("final result did not end the item");

endmodule

// File: test/bilinear_image_upscaler_unit_tb.sv
module bilinear_image_upscaler_unit_tb;
  import biu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned LINE_DEPTH    = MAX_WIDTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned QUIET_LIMIT   = 5000;

  typedef enum logic {
    PLAN_PIXEL,
    PLAN_WRITE
  } plan_kind_e;

  typedef struct packed {
    plan_kind_e           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [IMG_W_W-1:0]   data;
    logic                 typed;
    logic [PIX_W-1:0]     want;
  } plan_row_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   value;
    logic               last;
  } out_px_t;

  function automatic plan_row_t wr(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [IMG_W_W-1:0] data);
    return '{PLAN_WRITE, idx, data, 1'b0, '0};
  endfunction

  function automatic plan_row_t px(input logic [PIX_W-1:0] v);
    return '{PLAN_PIXEL, '0, {3'b000, v}, 1'b0, '0};
  endfunction

  // last pixel of a flat image: every output of its block equals v
  function automatic plan_row_t px_flat(input logic [PIX_W-1:0] v);
    return '{PLAN_PIXEL, '0, {3'b000, v}, 1'b1, v};
  endfunction

  localparam plan_row_t DIRECTED [32] = '{
    wr(REG_SCALE, 11'h7F8), wr(REG_IMAGE_WIDTH, 11'd1),
    px(8'd255), px(8'd255), px(8'd255), px_flat(8'd255),
    px(8'd0), px(8'd0), px(8'd0), px_flat(8'd0),
    wr(REG_SCALE, 11'd4), wr(REG_IMAGE_WIDTH, 11'd2),
    px(8'd255), px(8'd255), px(8'd255), px_flat(8'd255),
    px(8'd0), px(8'd255), px(8'd255), px(8'd0),
    wr(REG_SCALE, 11'd3), wr(REG_IMAGE_WIDTH, 11'd3),
    px(8'd1), px(8'd254), px(8'd128), px(8'd127),
    wr(REG_UNUSED, 11'h555),
    px(8'd200), px(8'd3), px(8'd90), px(8'd255), px(8'd0)
  };

  localparam int unsigned IDLE_MODE  [4] = '{0, 74, 0, 31};
  localparam int unsigned STALL_MODE [4] = '{0, 0, 74, 31};

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     pixel_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [COORD_W-1:0]   out_row_o;
  logic [COORD_W-1:0]   out_col_o;
  logic [PIX_W-1:0]     value_o;
  logic                 last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [IMG_W_W-1:0]   cfg_data_i  = '0;

  // shadow of the block's state
  logic [PIX_W-1:0]   line_mem [LINE_DEPTH];
  logic [PIX_W-1:0]   left_px   = '0;
  logic [PIX_W-1:0]   upleft_px = '0;
  int unsigned        src_row   = 0;
  int unsigned        src_col   = 0;
  logic [SCALE_W-1:0] scale_cfg = SCALE_RESET;
  logic [IMG_W_W-1:0] width_cfg = WIDTH_RESET;

  out_px_t     pending_px [$];
  out_px_t     want_px;
  int unsigned errors       = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned quiet_cycles = 0;

  bilinear_image_upscaler_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .value_o     (value_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [PIX_W-1:0] blend(input int unsigned s, i, j,
                                             input int unsigned p00, p01, p10, p11);
    int unsigned top, bot, num, quo;
    top = (s - i) * p00 + i * p01;
    bot = (s - i) * p10 + i * p11;
    num = (s - j) * top + j * bot;
    quo = (2 * num + s * s) / (2 * s * s);
    return (quo > 255) ? 8'd255 : PIX_W'(quo);
  endfunction

  // expected outputs of one accepted pixel; advance the shadow state
  task automatic upscale_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                               input logic [PIX_W-1:0] want);
    int unsigned s, w, r, c, rows, cols, i, j, upper;
    out_px_t e;
    s = (scale_cfg == 0) ? 1 : (scale_cfg > SCALE_MAX) ? SCALE_MAX : scale_cfg;
    w = (width_cfg < 2) ? 2 : (width_cfg > LINE_DEPTH) ? LINE_DEPTH : width_cfg;
    if (src_row >= w || src_col >= w) begin
      src_row = 0;
      src_col = 0;
    end
    r = src_row;
    c = src_col;
    upper = line_mem[c];
    if (r >= 1 && c >= 1) begin
      // last source row and column stretch to the output edge
      rows = (r == w - 1) ? 2 * s : s;
      cols = (c == w - 1) ? 2 * s : s;
      for (int y = 0; y < rows; y++) begin
        j = (y < s) ? y : s;
        for (int x = 0; x < cols; x++) begin
          i = (x < s) ? x : s;
          e.row   = COORD_W'((r - 1) * s + y);
          e.col   = COORD_W'((c - 1) * s + x);
          e.value = typed ? want : blend(s, i, j, upleft_px, upper, left_px, pix);
          e.last  = (y == rows - 1) && (x == cols - 1);
          pending_px.push_back(e);
        end
      end
    end
    upleft_px   = PIX_W'(upper);
    left_px     = pix;
    line_mem[c] = pix;
    if (c + 1 >= w) begin
      src_col = 0;
      src_row = (r + 1 >= w) ? 0 : r + 1;
    end else begin
      src_col = c + 1;
    end
  endtask

  task automatic flag_error(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    errors++;
    if (errors <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // leaves valid high so back-to-back items need no extra edge
  task automatic feed_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                            input logic [PIX_W-1:0] want);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= pix;
    do @(posedge clk_i); while (in_stall_o);
    upscale_pixel(pix, typed, want);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_px.size() != 0);
  endtask

  // an item with no output may still be in flight after the queue empties
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [IMG_W_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SCALE: begin
        scale_cfg = data[SCALE_W-1:0];
        src_row   = 0;
        src_col   = 0;
      end
      REG_IMAGE_WIDTH: begin
        width_cfg = data;
        src_row   = 0;
        src_col   = 0;
      end
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [IMG_W_W-1:0] scale_data, width_data,
                           input int unsigned count, mode);
    settle();
    write_reg(REG_SCALE, scale_data);
    write_reg(REG_IMAGE_WIDTH, width_data);
    cfg_valid_i <= 1'b0;
    idle_pct  = IDLE_MODE[mode];
    stall_pct = STALL_MODE[mode];
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) drain();
      feed_pixel(rand_pixel(), 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_px.size() == 0) begin
        flag_error("unexpected item, row", 0, out_row_o);
      end else begin
        want_px = pending_px.pop_front();
        if (out_row_o !== want_px.row) flag_error("out_row", want_px.row, out_row_o);
        if (out_col_o !== want_px.col) flag_error("out_col", want_px.col, out_col_o);
        if (value_o !== want_px.value) flag_error("value", want_px.value, value_o);
        if (last_o !== want_px.last) flag_error("last", want_px.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bilinear_image_upscaler_unit_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned wd, wv;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: scale 2, 512 wide; the first row gives no result
    for (int n = 0; n < 6; n++) feed_pixel(rand_pixel(), 1'b0, '0);

    for (int n = 0; n < $size(DIRECTED); n++) begin
      if (DIRECTED[n].kind == PLAN_WRITE) begin
        if (n == 0 || DIRECTED[n - 1].kind != PLAN_WRITE) settle();
        write_reg(DIRECTED[n].idx, DIRECTED[n].data);
        if (n == $size(DIRECTED) - 1 || DIRECTED[n + 1].kind != PLAN_WRITE) begin
          cfg_valid_i <= 1'b0;
        end
      end else begin
        feed_pixel(DIRECTED[n].data[PIX_W-1:0], DIRECTED[n].typed, DIRECTED[n].want);
      end
    end

    // small images, every scale code, widths below the minimum too
    for (int k = 0; k < 14; k++) begin
      if (k == 3) wd = 0;
      else if (k == 9) wd = 1;
      else wd = $urandom_range(2, 5);
      wv = (wd < 2) ? 2 : wd;
      run_phase({8'($urandom_range(0, 255)), 3'(k % 8)}, IMG_W_W'(wd),
                wv * wv + $urandom_range(0, wv * wv), k % 4);
    end

    // widest image and a width above the maximum: first row only
    run_phase(11'd4, 11'd1024, 6, 3);
    run_phase(11'h7FD, 11'h7FF, 6, 2);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_px.size() != 0) flag_error("items still pending", 0, pending_px.size());
    if (errors == 0) begin
      $display("bilinear_image_upscaler_unit_tb: done, clean");
    end else begin
      $display("bilinear_image_upscaler_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
